/* src/iot_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the orientation core.
package iot_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int CHANNELS    = 3;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int PIX_W   = 8 * CHANNELS;
  localparam int DIM_W   = 9;
  localparam int COORD_W = 8;
  localparam int MODE_W  = 3;
  localparam int COUNT_W = 17;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CFG_IDX_W = 2;

  // One restoring-division step per quotient bit of the emit counter.
  localparam int DIV_STEPS = COUNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_MODE  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT90    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT180   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT270   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLIP_H   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FLIP_V   = 3'd5;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(MAX_HEIGHT);

  typedef struct packed {
    logic load;
    logic read_start;
    logic sync_init;
    logic div_step;
    logic sync_load;
    logic addr_calc;
    logic mem_read;
  } iot_cmd_t;

  typedef struct packed {
    logic dirty;
    logic full;
  } iot_status_t;

endpackage

/* src/image_orientation_transform_core.sv */
// Top level of the frame store that rotates or flips one image at a time.
//
//   Channel   Direction  Signals                          Handshake
//   request   in         opcode, pixel_in                 start && !busy
//   result    out        pixel_out, frame_last            done, one cycle, no stall
//   config    in         cfg_index, cfg_data              cfg_write
//
// A load transaction writes the pixel into the frame store at the accepting edge, and busy
// stays low. A read transaction on a full frame passes through accept, source address
// multiply, registered frame store read, and the done strobe. A read before the frame is
// full finishes at once with no result.
// After reset and after every write to one of the three defined registers the block runs
// a resync with busy high: it recomputes the pixel count and splits the emit counter into
// output row and column with a bit-serial divider, one quotient bit per cycle.
// A write to the unused register index changes nothing and starts no resync.
// Reset is synchronous and active high. The receiver cannot stall, so each result is
// valid only in the cycle where done is high.
module image_orientation_transform_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode,
  input  logic [iot_pkg::PIX_W-1:0]     pixel_in,
  output logic                          done,
  output logic [iot_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_last,
  input  logic                          cfg_write,
  input  logic [iot_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iot_pkg::DIM_W-1:0]     cfg_data
);

  // Commands flow from the controller into the datapath; the datapath reports
  // whether a resync is pending and whether the frame is full.
  iot_pkg::iot_cmd_t    cmd;
  iot_pkg::iot_status_t status;

  iot_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  iot_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_in),
    .cmd        (cmd),
    .status     (status),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

/* src/iot_ctrl.sv */
// Controller state machine that sequences loads, reads and the position resync.
module iot_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  iot_pkg::iot_status_t status,
  output logic                busy,
  output logic                done,
  output iot_pkg::iot_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV      = 3'd1;
  localparam logic [2:0] S_SYNC_END = 3'd2;
  localparam logic [2:0] S_ADDR     = 3'd3;
  localparam logic [2:0] S_READ     = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0]                    state;
  logic [2:0]                    state_next;
  logic [iot_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [iot_pkg::DIV_CNT_W-1:0] div_cnt_next;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        div_cnt_next = '0;
        if (status.dirty) begin
          cmd.sync_init = 1'b1;
          state_next    = S_DIV;
        end else if (start) begin
          if (opcode == iot_pkg::OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (status.full) begin
            cmd.read_start = 1'b1;
            state_next     = S_ADDR;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == iot_pkg::DIV_CNT_W'(iot_pkg::DIV_STEPS - 1)) begin
          state_next = S_SYNC_END;
        end
      end
      S_SYNC_END: begin
        cmd.sync_load = 1'b1;
        state_next    = S_IDLE;
      end
      S_ADDR: begin
        cmd.addr_calc = 1'b1;
        state_next    = S_READ;
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  assign busy = (state != S_IDLE) || status.dirty;
  assign done = (state == S_OUT);

endmodule

/* src/iot_datapath.sv */
// Datapath: configuration registers, frame store, counters, divider and address unit.
module iot_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [iot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iot_pkg::DIM_W-1:0]        cfg_data,
  input  logic [iot_pkg::PIX_W-1:0]        pixel_in,
  input  iot_pkg::iot_cmd_t                cmd,
  output iot_pkg::iot_status_t             status,
  output logic [iot_pkg::PIX_W-1:0]        pixel_out,
  output logic                             frame_last
);

  logic [iot_pkg::DIM_W-1:0]   frame_width;
  logic [iot_pkg::DIM_W-1:0]   frame_height;
  logic [iot_pkg::MODE_W-1:0]  orient_mode;
  logic                        dirty;
  logic [iot_pkg::COUNT_W-1:0] total;
  logic [iot_pkg::COUNT_W-1:0] load_count;
  logic [iot_pkg::COUNT_W-1:0] emit_count;
  logic [iot_pkg::COORD_W-1:0] row;
  logic [iot_pkg::COORD_W-1:0] col;
  logic [iot_pkg::DIM_W-1:0]   div_rem;
  logic [iot_pkg::COUNT_W-1:0] div_quo;
  logic [iot_pkg::ADDR_W-1:0]  rd_addr;
  logic [iot_pkg::PIX_W-1:0]   rdata;
  logic                        last;

  logic [iot_pkg::PIX_W-1:0]   frame_store [iot_pkg::STORE_DEPTH];

  logic [iot_pkg::DIM_W-1:0]   w_eff;
  logic [iot_pkg::DIM_W-1:0]   h_eff;
  logic [iot_pkg::DIM_W-1:0]   out_w;
  logic [iot_pkg::DIM_W:0]     div_shift;
  logic                        div_take;
  logic [iot_pkg::DIM_W-1:0]   row_x;
  logic [iot_pkg::DIM_W-1:0]   col_x;
  logic [iot_pkg::DIM_W-1:0]   src_row;
  logic [iot_pkg::DIM_W-1:0]   src_col;
  logic [2*iot_pkg::DIM_W-1:0] addr_sum;
  logic [2*iot_pkg::DIM_W-1:0] dim_prod;
  logic [iot_pkg::COUNT_W-1:0] emit_inc;
  logic                        full;

  // Sizes out of range saturate into 1..MAX.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = iot_pkg::DIM_W'(1);
    end else if (frame_width > iot_pkg::DIM_W'(iot_pkg::MAX_WIDTH)) begin
      w_eff = iot_pkg::DIM_W'(iot_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = iot_pkg::DIM_W'(1);
    end else if (frame_height > iot_pkg::DIM_W'(iot_pkg::MAX_HEIGHT)) begin
      h_eff = iot_pkg::DIM_W'(iot_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Quarter turns swap the output dimensions.
  assign out_w = (orient_mode == iot_pkg::MODE_ROT90 || orient_mode == iot_pkg::MODE_ROT270)
                 ? h_eff : w_eff;

  assign dim_prod  = w_eff * h_eff;
  assign full      = (load_count >= total);
  assign emit_inc  = emit_count + 1'b1;

  assign div_shift = {div_rem, div_quo[iot_pkg::COUNT_W-1]};
  assign div_take  = (div_shift >= {1'b0, out_w});

  assign row_x = {1'b0, row};
  assign col_x = {1'b0, col};

  always_comb begin
    case (orient_mode)
      iot_pkg::MODE_ROT90: begin
        src_row = h_eff - 1'b1 - col_x;
        src_col = row_x;
      end
      iot_pkg::MODE_ROT180: begin
        src_row = h_eff - 1'b1 - row_x;
        src_col = w_eff - 1'b1 - col_x;
      end
      iot_pkg::MODE_ROT270: begin
        src_row = col_x;
        src_col = w_eff - 1'b1 - row_x;
      end
      iot_pkg::MODE_FLIP_H: begin
        src_row = row_x;
        src_col = w_eff - 1'b1 - col_x;
      end
      iot_pkg::MODE_FLIP_V: begin
        src_row = h_eff - 1'b1 - row_x;
        src_col = col_x;
      end
      default: begin
        src_row = row_x;
        src_col = col_x;
      end
    endcase
  end

  assign addr_sum = src_row * w_eff + {{iot_pkg::DIM_W{1'b0}}, src_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= iot_pkg::WIDTH_RESET;
      frame_height <= iot_pkg::HEIGHT_RESET;
      orient_mode  <= iot_pkg::MODE_IDENTITY;
      dirty        <= 1'b1;
      total        <= '0;
      load_count   <= '0;
      emit_count   <= '0;
      row          <= '0;
      col          <= '0;
      last         <= 1'b0;
    end else begin
      if (cmd.sync_init) begin
        dirty <= 1'b0;
        total <= dim_prod[iot_pkg::COUNT_W-1:0];
      end
      if (cfg_write) begin
        unique case (cfg_index)
          iot_pkg::CFG_FRAME_WIDTH: begin
            frame_width <= cfg_data;
            dirty       <= 1'b1;
          end
          iot_pkg::CFG_FRAME_HEIGHT: begin
            frame_height <= cfg_data;
            dirty        <= 1'b1;
          end
          iot_pkg::CFG_ORIENT_MODE: begin
            orient_mode <= cfg_data[iot_pkg::MODE_W-1:0];
            dirty       <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.load && !full) begin
        load_count <= load_count + 1'b1;
      end
      if (cmd.sync_load) begin
        row <= div_quo[iot_pkg::COORD_W-1:0];
        col <= div_rem[iot_pkg::COORD_W-1:0];
      end
      if (cmd.read_start && (emit_count >= total)) begin
        emit_count <= '0;
        row        <= '0;
        col        <= '0;
      end
      if (cmd.mem_read) begin
        if (emit_inc >= total) begin
          last       <= 1'b1;
          emit_count <= '0;
          load_count <= '0;
          row        <= '0;
          col        <= '0;
        end else begin
          last       <= 1'b0;
          emit_count <= emit_inc;
          if (col_x == out_w - 1'b1) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
      end
    end
  end

  // Divider and address registers carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.sync_init) begin
      div_rem <= '0;
      div_quo <= emit_count;
    end else if (cmd.div_step) begin
      if (div_take) begin
        div_rem <= iot_pkg::DIM_W'(div_shift - {1'b0, out_w});
      end else begin
        div_rem <= div_shift[iot_pkg::DIM_W-1:0];
      end
      div_quo <= {div_quo[iot_pkg::COUNT_W-2:0], div_take};
    end
    if (cmd.addr_calc) begin
      rd_addr <= addr_sum[iot_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      frame_store[load_count[iot_pkg::ADDR_W-1:0]] <= pixel_in;
    end
    if (cmd.mem_read) begin
      rdata <= frame_store[rd_addr];
    end
  end

  assign status.dirty = dirty;
  assign status.full  = full;
  assign pixel_out    = rdata;
  assign frame_last   = last;

endmodule

/* src/iot_checker.sv */
// Port-level checker for the orientation core and its bind statement.
module iot_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result strobe lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted transaction never produces a result in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe right after an accepted transaction");

  // While a result is shown the block accepts nothing.
  a_busy_on_done: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("block ready while presenting a result");

  // Reset starts the resync, so the block is busy right after it.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

endmodule

bind image_orientation_transform_core iot_checker u_iot_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* tb/sv/testbench.sv */
// Self-checking testbench for the image orientation transform core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iot_pkg::*;

  // Number of random load/read transactions in the random part of the run.
  localparam int RANDOM_ITEMS = 280;
  // Cycles allowed after the last expected pixel before a register write or the end of the
  // run. A read on a frame that is not full produces no pixel and finishes at once, so
  // this only gives a stray result strobe room to show up after the read path.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any accepted transaction, pixel or register write before giving up.
  // The longest quiet stretch in a correct run is the settle time plus the resync
  // plus one idle burst.
  localparam int STALL_LIMIT = 2000;

  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Orientation codes with no defined meaning; the core treats them as identity.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pixel_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               opcode = OP_LOAD;
  logic [PIX_W-1:0]   pixel_in = '0;
  logic               done;
  logic [PIX_W-1:0]   pixel_out;
  logic               frame_last;
  logic               cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]   cfg_data = '0;

  // Shadow copy of the core state, updated at the edge where each transaction is taken.
  logic [PIX_W-1:0]   shadow_frame [STORE_DEPTH];
  logic [COUNT_W-1:0] loaded_pixels;
  logic [COUNT_W-1:0] emitted_pixels;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [MODE_W-1:0]  mode_reg;

  // Pixels the core still owes us, oldest first.
  pixel_result_t      pending_pixels [$];

  logic               frame_closed = 1'b0;
  logic               idle_enable = 1'b1;
  int                 items_sent = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  image_orientation_transform_core dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .pixel_in   (pixel_in),
    .done       (done),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  // Out-of-range sizes are saturated into 1..hi whenever they are used.
  function automatic int unsigned dim_clamp(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == '0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return dim_clamp(width_reg, MAX_WIDTH) * dim_clamp(height_reg, MAX_HEIGHT);
  endfunction

  // Applies one accepted transaction to the shadow state and queues the pixel it yields.
  function automatic void orient_predict(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned   w, h, total, out_w, row, col, src_row, src_col;
    pixel_result_t res;
    w = dim_clamp(width_reg, MAX_WIDTH);
    h = dim_clamp(height_reg, MAX_HEIGHT);
    total = w * h;
    if (op == OP_LOAD) begin
      // A load into a full frame is dropped without a trace.
      if (loaded_pixels < total) begin
        shadow_frame[loaded_pixels] = pix;
        loaded_pixels = loaded_pixels + 1'b1;
      end
      return;
    end
    // A read on a frame that is still filling yields nothing and changes nothing.
    if (loaded_pixels < total) return;
    // The frame may have shrunk while it was being read out; restart the readout then.
    if (emitted_pixels >= total) emitted_pixels = '0;
    // Quarter turns swap the output dimensions.
    out_w = (mode_reg == MODE_ROT90 || mode_reg == MODE_ROT270) ? h : w;
    row = emitted_pixels / out_w;
    col = emitted_pixels % out_w;
    case (mode_reg)
      MODE_ROT90: begin
        src_row = h - 1 - col;
        src_col = row;
      end
      MODE_ROT180: begin
        src_row = h - 1 - row;
        src_col = w - 1 - col;
      end
      MODE_ROT270: begin
        src_row = col;
        src_col = w - 1 - row;
      end
      MODE_FLIP_H: begin
        src_row = row;
        src_col = w - 1 - col;
      end
      MODE_FLIP_V: begin
        src_row = h - 1 - row;
        src_col = col;
      end
      default: begin
        src_row = row;
        src_col = col;
      end
    endcase
    res.pixel = shadow_frame[src_row * w + src_col];
    emitted_pixels = emitted_pixels + 1'b1;
    res.last = (emitted_pixels >= total);
    if (res.last) begin
      // The frame is consumed: both counters start over for the next image.
      emitted_pixels = '0;
      loaded_pixels = '0;
      frame_closed = 1'b1;
    end
    pending_pixels.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // The receiver cannot stall, so every cycle with done high carries one pixel that has to
  // match the oldest pending prediction.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %06h last %0b", pixel_out, frame_last));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want.pixel)
          report_mismatch($sformatf("pixel_out %06h, predicted %06h", pixel_out, want.pixel));
        if (frame_last !== want.last)
          report_mismatch($sformatf("frame_last %0b, predicted %0b", frame_last, want.last));
      end
    end
  end

  // Ends a run that has stopped making progress. A register write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Presents one transaction and holds it until the core takes it. Start stays high when the
  // next transaction follows right away, so back-to-back transfers do not drop start in between.
  task automatic send_item(input logic op, input logic [PIX_W-1:0] pix);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    pixel_in <= pix;
    do @(posedge clk); while (busy);
    orient_predict(op, pix);
    items_sent++;
  endtask

  // Register writes happen only with the core idle: every predicted pixel is back, a read
  // that produced nothing has had time to finish, and the resync after the last write is
  // over. The final wait at the end lets busy rise before the next write looks at it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = data;
      CFG_FRAME_HEIGHT: height_reg = data;
      CFG_ORIENT_MODE:  mode_reg = data[MODE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [MODE_W-1:0] mode);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_ORIENT_MODE, DIM_W'(mode));
  endtask

  // Loads random pixels until the frame is full. With noise on, an occasional early read
  // is mixed in; it must come back empty.
  task automatic fill_frame(input bit noise);
    while (loaded_pixels < frame_pixels()) begin
      if (noise && $urandom_range(0, 15) == 0)
        send_item(OP_READ, PIX_W'($urandom));
      else
        send_item(OP_LOAD, PIX_W'($urandom));
    end
  endtask

  // Reads until the last pixel of the frame has been requested. With noise on, an occasional
  // load into the full frame is mixed in; it must be dropped.
  task automatic drain_frame(input bit noise);
    frame_closed = 1'b0;
    while (!frame_closed) begin
      if (noise && $urandom_range(0, 15) == 0)
        send_item(OP_LOAD, PIX_W'($urandom));
      else
        send_item(OP_READ, PIX_W'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Out of reset the frame is 256 by 256 and empty, so a read transaction gets nothing.
  task automatic test_read_before_full();
    send_item(OP_READ, PIX_W'($urandom));
    send_item(OP_LOAD, PIX_W'($urandom));
  endtask

  // A non-square frame turned a quarter clockwise, loaded with the extreme pixel values,
  // with an early read and a load past the end of the frame.
  task automatic test_quarter_turn();
    configure(9'd2, 9'd3, MODE_ROT90);
    send_item(OP_LOAD, '0);
    send_item(OP_LOAD, '1);
    send_item(OP_READ, '1);
    fill_frame(1'b0);
    send_item(OP_LOAD, PIX_W'($urandom));
    drain_frame(1'b0);
  endtask

  // The frame shrinks while it is being read out, past the point already emitted, so the
  // readout restarts from the first pixel of the smaller frame.
  task automatic test_shrink_during_output();
    configure(9'd2, 9'd2, MODE_FLIP_H);
    fill_frame(1'b0);
    repeat (3) send_item(OP_READ, PIX_W'($urandom));
    write_reg(CFG_FRAME_WIDTH, 9'd1);
    drain_frame(1'b0);
  endtask

  // A zero width saturates to one, undefined orientation codes act as identity, and a
  // write to the unused register index changes nothing.
  task automatic test_out_of_range_settings();
    configure(9'd0, 9'd2, MODE_SPARE_HI);
    write_reg(CFG_SPARE, DIM_W'($urandom));
    fill_frame(1'b0);
    drain_frame(1'b0);
    write_reg(CFG_ORIENT_MODE, DIM_W'(MODE_SPARE_LO));
    write_reg(CFG_FRAME_HEIGHT, 9'd0);
    fill_frame(1'b0);
    drain_frame(1'b0);
  endtask

  // The largest dimensions: an oversized width that saturates to the maximum in a single
  // row, then a full-height single column that takes over the readout part way through,
  // and last a shrink that restarts the readout of the now tiny frame.
  task automatic test_extreme_sizes();
    configure(9'd511, 9'd1, MODE_ROT90);
    fill_frame(1'b1);
    repeat (3) send_item(OP_READ, PIX_W'($urandom));
    configure(9'd1, 9'd256, MODE_ROT270);
    repeat (3) send_item(OP_READ, PIX_W'($urandom));
    write_reg(CFG_FRAME_HEIGHT, 9'd2);
    drain_frame(1'b1);
  endtask

  // Random frames: mostly complete load and readout sequences at small sizes in every
  // orientation, some with settings kept from the previous frame, some cut off halfway so
  // that the next settings apply to a frame in progress. Idling stops near the end.
  task automatic test_random_frames();
    int first_item;
    int choice;
    int cut;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      idle_enable = (items_sent - first_item < RANDOM_ITEMS * 4 / 5);
      choice = $urandom_range(0, 7);
      if (choice < 5) begin
        configure(DIM_W'($urandom_range(0, 6)), DIM_W'($urandom_range(0, 6)),
                  MODE_W'($urandom_range(0, 7)));
      end else if (choice == 5) begin
        write_reg(CFG_ORIENT_MODE, DIM_W'($urandom_range(0, 7)));
      end
      fill_frame(1'b1);
      if ($urandom_range(0, 5) == 0) begin
        frame_closed = 1'b0;
        cut = $urandom_range(1, 8);
        for (int k = 0; k < cut && !frame_closed; k++)
          send_item(OP_READ, PIX_W'($urandom));
      end else begin
        drain_frame(1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    // Shadow state after reset.
    loaded_pixels = '0;
    emitted_pixels = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    mode_reg = MODE_IDENTITY;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_read_before_full();
    test_quarter_turn();
    test_shrink_during_output();
    test_out_of_range_settings();
    test_extreme_sizes();
    test_random_frames();

    // Let the last pixels come back, then give a stray strobe time to show up.
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
src/iot_pkg.sv
src/iot_ctrl.sv
src/iot_datapath.sv
src/image_orientation_transform_core.sv
src/iot_checker.sv
tb/sv/testbench.sv
